@@ rtl/core/pcts_pkg.sv @@
// Shared constants, types and state codes for the percentile selector.
package pcts_pkg;

  // Chain geometry
  localparam int NUM_CELLS = 64;
  localparam int IDX_W     = $clog2(NUM_CELLS);
  localparam int CNT_W     = $clog2(NUM_CELLS + 1);

  // Field widths
  localparam int SAMPLE_W = 32;
  localparam int PCT_W    = 14;
  localparam int PROD_W   = 20;   // holds PCT_FULL * NUM_CELLS plus one step

  localparam logic [PCT_W-1:0]  PCT_FULL   = 14'd10000;
  localparam logic [PCT_W-1:0]  PCT_RESET  = 14'd5000;
  localparam logic [PROD_W-1:0] RANK_STEP  = 20'd10000;
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(NUM_CELLS);
  localparam logic [IDX_W-1:0]  SETTLE_END = IDX_W'(NUM_CELLS - 1);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_SHIFT,
    ST_DONE
  } pcts_state_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic clear;   // drop all stored samples
    logic shift;   // move every value one cell toward the head
  } cell_ctl_t;

endpackage

@@ rtl/core/pcts_cell.sv @@
// One cell of the sorted chain: keeps the smaller value, hands the larger on.
module pcts_cell
  import pcts_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctl_t                  ctl,
  input  logic                       ins_vld,
  input  logic signed [SAMPLE_W-1:0] ins_val,
  input  logic signed [SAMPLE_W-1:0] nbr_val,
  output logic signed [SAMPLE_W-1:0] val_o,
  output logic                       pass_vld_o,
  output logic signed [SAMPLE_W-1:0] pass_val_o
);

  logic                       vld_r;
  logic signed [SAMPLE_W-1:0] val_r;
  logic                       pass_vld_r;
  logic signed [SAMPLE_W-1:0] pass_val_r;
  logic                       ins_less;

  assign ins_less = ins_val < val_r;

  // Occupancy and forwarding control
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      vld_r      <= 1'b0;
      pass_vld_r <= 1'b0;
    end else begin
      pass_vld_r <= ins_vld && vld_r;
      if (ins_vld) begin
        vld_r <= 1'b1;
      end
    end
  end

  // Stored value and forwarded value
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val_r <= nbr_val;
    end else if (ins_vld && (!vld_r || ins_less)) begin
      val_r <= ins_val;
    end
    pass_val_r <= ins_less ? val_r : ins_val;
  end

  assign val_o      = val_r;
  assign pass_vld_o = pass_vld_r;
  assign pass_val_o = pass_val_r;

endmodule

@@ rtl/core/pcts_ctrl.sv @@
// Sequencer: set loading, rank search by shifting the chain, result register.
module pcts_ctrl
  import pcts_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [PCT_W-1:0]           cfg_wr_data,
  input  logic                       in_beat,
  input  logic                       in_last,
  output logic                       in_ready,
  output logic                       ins_vld,
  output cell_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] head_val,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_selected,
  output logic                       out_status
);

  pcts_state_t state_r, state_nxt;

  logic [PCT_W-1:0]  pct_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [IDX_W-1:0]  timer_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] acc_r;
  logic              out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sel_r;
  logic              out_stat_r;

  logic              full;
  logic [CNT_W-1:0]  set_n;
  logic [PCT_W-1:0]  pct_sat;
  logic [PROD_W-1:0] prod_nxt;
  logic              rank_more;
  logic              out_free;

  assign full      = (count_r == CNT_FULL);
  assign set_n     = full ? count_r : count_r + 1'b1;
  assign pct_sat   = (pct_r > PCT_FULL) ? PCT_FULL : pct_r;
  assign prod_nxt  = PROD_W'(pct_sat) * PROD_W'(set_n);
  assign rank_more = acc_r < prod_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:   if (in_beat && in_last) state_nxt = ST_SETTLE;
      ST_SETTLE: if (timer_r == SETTLE_END) state_nxt = ST_SHIFT;
      ST_SHIFT:  if (!rank_more) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_LOAD;
      default:   state_nxt = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    ins_vld   = 1'b0;
    ctl       = '0;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_beat) begin
          ins_vld   = !full;
          count_nxt = set_n;
          ovf_nxt   = ovf_r | full;
        end
      end
      ST_SETTLE: ;
      ST_SHIFT:  ctl.shift = rank_more;
      ST_DONE: begin
        if (out_free) begin
          ctl.clear = 1'b1;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      pct_r       <= PCT_RESET;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        pct_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      timer_r <= (state_r == ST_SETTLE) ? timer_r + 1'b1 : '0;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Rank search and result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && in_beat && in_last) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_SETTLE) begin
      acc_r <= RANK_STEP;
    end else if (state_r == ST_SHIFT && rank_more) begin
      acc_r <= acc_r + RANK_STEP;
    end
    if (state_r == ST_DONE && out_free) begin
      out_sel_r  <= head_val;
      out_stat_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_selected = out_sel_r;
  assign out_status   = out_stat_r;

endmodule

@@ rtl/core/percentile_select.sv @@
// Top level: nearest-rank percentile over a streamed set of samples.
//
// Input beats carry one signed Q16.16 sample each; tlast marks the final
// sample of a set. Up to 64 samples are kept; later ones are dropped and the
// result's status bit is set. Each stored sample enters a chain of 64 sorting
// cells at one beat per cycle while the input is ready, and ripples toward
// its place. After the last beat the chain settles, then shifts toward its
// head once per rank step (ceil(p*n/10000)-1 shifts, 0 to 63), makes the
// closing rank compare and, once the output register is free, loads the
// head value into it. The input is not ready from the last beat until the
// result is registered; the next set can start as soon as it is. The
// percentile register is to be written by the user through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block does not enforce this.
// Values above 10000 act as 10000.
// If the receiver stalls, the result waits in the output register and the
// next set can be loaded and sorted; only its own result then waits.
// Reset clears the set, the output valid and sets the percentile to 5000.
module percentile_select
  import pcts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [PCT_W-1:0]     cfg_wr_data,   // percentile_hundredths
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [SAMPLE_W-1:0]  in_tdata,      // [31:0] sample
  input  logic                 in_tlast,      // last
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SAMPLE_W-1:0]  out_tdata,     // [31:0] selected
  output logic                 out_tuser      // [0] status
);

  cell_ctl_t                  ctl;
  logic                       in_beat;
  logic                       ins_vld;
  logic signed [SAMPLE_W-1:0] out_selected;
  logic signed [SAMPLE_W-1:0] vals     [NUM_CELLS];
  logic                       chain_vld[NUM_CELLS+1];
  logic signed [SAMPLE_W-1:0] chain_val[NUM_CELLS+1];

  assign in_beat = in_tvalid && in_tready;

  // Sequencer
  pcts_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_beat      (in_beat),
    .in_last      (in_tlast),
    .in_ready     (in_tready),
    .ins_vld      (ins_vld),
    .ctl          (ctl),
    .head_val     (vals[0]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_selected (out_selected),
    .out_status   (out_tuser)
  );

  assign chain_vld[0] = ins_vld;
  assign chain_val[0] = $signed(in_tdata);

  // Sorting chain, smallest value at the head
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] nbr;
    if (i == NUM_CELLS - 1) begin : g_tail
      assign nbr = vals[i];
    end else begin : g_mid
      assign nbr = vals[i+1];
    end
    pcts_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .ins_vld    (chain_vld[i]),
      .ins_val    (chain_val[i]),
      .nbr_val    (nbr),
      .val_o      (vals[i]),
      .pass_vld_o (chain_vld[i+1]),
      .pass_val_o (chain_val[i+1])
    );
  end

  assign out_tdata = out_selected;

endmodule

@@ tb/percentile_select_tb.sv @@
// Testbench for percentile_select: streamed sample sets checked against a nearest-rank predictor.
module percentile_select_tb
  import pcts_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 200;     // settle + deepest shift + output register

  typedef struct packed {
    logic [SAMPLE_W-1:0] selected;
    logic                status;
  } pct_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [PCT_W-1:0]    cfg_wr_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;    // [31:0] sample
  logic                in_tlast = 1'b0;  // last
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;        // [31:0] selected
  logic                out_tuser;        // [0] status

  // Predictor state
  logic signed [SAMPLE_W-1:0] held_samples[$];
  logic                       dropped_seen;
  logic [PCT_W-1:0]           pct_setting;
  pct_result_t                pct_due[$];

  int  errors = 0;
  int  beats_sent = 0;
  int  cycles = 0;
  int  ready_hold = 0;
  bit  steady = 1'b0;   // no gaps, no stalls

  percentile_select dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return SAMPLE_W'($signed($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Nearest-rank pick over the held set: rank ceil(p*n/10000)-1, clamped to [0, n-1]
  function automatic logic [SAMPLE_W-1:0] nearest_rank_pick();
    logic signed [SAMPLE_W-1:0] srt[NUM_CELLS];
    logic signed [SAMPLE_W-1:0] key;
    int n;
    int p;
    int rank;
    int j;
    n = held_samples.size();
    for (int i = 0; i < n; i++) begin
      key = held_samples[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    p = (pct_setting > PCT_FULL) ? int'(PCT_FULL) : int'(pct_setting);
    rank = (p * n + int'(PCT_FULL) - 1) / int'(PCT_FULL);
    rank = (rank > 0) ? rank - 1 : 0;
    if (rank >= n) rank = n - 1;
    return srt[rank];
  endfunction

  // Model one accepted beat
  function automatic void take_beat(input logic [SAMPLE_W-1:0] smp, input logic lst);
    pct_result_t r;
    if (held_samples.size() < NUM_CELLS) held_samples = {held_samples, $signed(smp)};
    else dropped_seen = 1'b1;
    if (lst) begin
      r.selected = nearest_rank_pick();
      r.status   = dropped_seen;
      pct_due = {pct_due, r};
      held_samples.delete();
      dropped_seen = 1'b0;
    end
  endfunction

  // Send one beat; valid stays up if the next beat follows at once
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_beat(smp, lst);
    beats_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_sample(rand_sample(), i == n - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pct_due.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic set_percentile(input logic [PCT_W-1:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pct_setting = v;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= steady || ($urandom_range(0, 3) != 0);
      ready_hold <= idle_len();
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    pct_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pct_due.size() == 0) begin
        $error("unexpected result beat: selected %h status %b", out_tdata, out_tuser);
        errors++;
      end else begin
        want = pct_due.pop_front();
        if (out_tdata !== want.selected) begin
          $error("selected: expected %h, actual %h", want.selected, out_tdata);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %b, actual %b", want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  // Reset value 5000: median of min, zero, max is zero
  task automatic test_default_median();
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h8000_0000, 1'b1);   // one-sample set
  endtask

  // Percentile zero selects the minimum
  task automatic test_percentile_zero();
    set_percentile('0);
    send_sample(32'h0005_0000, 1'b0);
    send_sample(32'hFFFD_0000, 1'b0);
    send_sample(32'h0009_8000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1);
  endtask

  // Full scale and saturated values select the maximum
  task automatic test_percentile_top();
    set_percentile(PCT_FULL);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h0000_0002, 1'b1);
    set_percentile({PCT_W{1'b1}});
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_0000, 1'b0);
    send_sample(32'h8000_0001, 1'b1);
    set_percentile(14'd10001);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
  endtask

  // Small and near-full percentiles
  task automatic test_rank_edges();
    set_percentile(14'd1);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'hEDCB_A988, 1'b1);
    set_percentile(14'd9999);
    send_sample(32'h0000_0003, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h0000_0002, 1'b1);
  endtask

  // Full store, one dropped beat (the last one), several dropped beats
  task automatic test_store_overflow();
    set_percentile(14'd5000);
    send_random_set(NUM_CELLS);
    send_random_set(NUM_CELLS + 1);
    set_percentile(PCT_FULL);
    send_random_set(NUM_CELLS + 6);
    set_percentile('0);
    send_random_set(NUM_CELLS + 2);
  endtask

  // Random sets, mostly small, with percentile changes between phases
  task automatic test_random_sets(input int target);
    int sets;
    int r;
    sets = 0;
    while (beats_sent < target) begin
      if (sets % 12 == 11) begin
        case ($urandom_range(0, 7))
          0: set_percentile('0);
          1: set_percentile(PCT_FULL);
          2: set_percentile({PCT_W{1'b1}});
          3: set_percentile(14'd1);
          4: set_percentile(14'd9999);
          default: set_percentile(PCT_W'($urandom_range(0, 16383)));
        endcase
      end
      steady = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) send_random_set($urandom_range(1, 8));
      else if (r < 88) send_random_set($urandom_range(9, 40));
      else if (r < 96) send_random_set($urandom_range(41, NUM_CELLS));
      else send_random_set($urandom_range(NUM_CELLS + 1, NUM_CELLS + 16));
      sets++;
    end
    steady = 1'b0;
  endtask

  // Sender holds off until every result is back, then resumes back to back
  task automatic test_drain_pause();
    send_random_set(5);
    send_random_set(3);
    wait_drained();
    steady = 1'b1;
    send_random_set(6);
    send_random_set(1);
    steady = 1'b0;
  endtask

  initial begin
    held_samples.delete();
    dropped_seen = 1'b0;
    pct_setting  = PCT_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_median();
    test_percentile_zero();
    test_percentile_top();
    test_rank_edges();
    test_store_overflow();
    test_drain_pause();
    test_random_sets(1100);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pcts_pkg.sv
rtl/core/pcts_cell.sv
rtl/core/pcts_ctrl.sv
rtl/core/percentile_select.sv
tb/percentile_select_tb.sv
